### rtl/csw_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the counting semaphore with waiter queue.
// No dependencies; used by the interfaces, the cell and the top level.
package csw_pkg;

  localparam int OPCODE_W = 3;
  localparam int IN_ID_W  = 8;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 31;
  localparam int WCOUNT_W = 5;

  localparam logic signed [31:0] BALANCE_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] BALANCE_BOTTOM = 32'sh8000_0000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SIGNAL  = 3'd0,
    OP_TRYWAIT = 3'd1,
    OP_WAIT    = 3'd2,
    OP_TIMEOUT = 3'd3,
    OP_RELEASE = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_UNAVAILABLE = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_TIMEDOUT    = 4'd3,
    ST_ALREADY     = 4'd4,
    ST_SIGNALLED   = 4'd5,
    ST_FULL        = 4'd6,
    ST_OVERFLOW    = 4'd7,
    ST_RELEASED    = 4'd8
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Broadcast controls from the sequencer to every queue cell.
  typedef struct packed {
    logic capture;  // latch id compare for a new request
    logic pop;      // whole queue shifts toward the head
    logic remove;   // cells at or behind the first match shift
    logic append;   // tail cell takes the request id
  } cell_ctrl_t;

endpackage

### rtl/csw_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with opcode and waiter id.
// Depends on csw_pkg.
interface csw_in_if;
  logic                          valid;
  logic                          ready;
  logic [csw_pkg::OPCODE_W-1:0]  opcode;
  logic [csw_pkg::IN_ID_W-1:0]   waiter_id;

  modport source (output valid, opcode, waiter_id, input ready);
  modport sink   (input valid, opcode, waiter_id, output ready);
endinterface

### rtl/csw_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with status, woken waiter and counts.
// Depends on csw_pkg.
interface csw_out_if;
  logic                          valid;
  logic                          ready;
  logic [csw_pkg::STATUS_W-1:0]  status;
  logic                          woken_valid;
  logic [csw_pkg::IN_ID_W-1:0]   woken_id;
  logic [csw_pkg::COUNT_W-1:0]   event_count;
  logic [csw_pkg::WCOUNT_W-1:0]  waiting_count;
  logic                          last;

  modport source (output valid, status, woken_valid, woken_id, event_count,
                  waiting_count, last, input ready);
  modport sink   (input valid, status, woken_valid, woken_id, event_count,
                  waiting_count, last, output ready);
endinterface

### rtl/counting_semaphore_with_waiter_queue.sv
`timescale 1ns / 1ps
// Counting semaphore with a FIFO of waiter ids, built on a row of queue cells.
// Depends on csw_pkg, csw_in_if, csw_out_if and csw_cell.
//
// Usage:
//  - in_chan carries requests (opcode, waiter_id); out_chan carries results.
//    Both use valid/ready; a transfer happens when both are high.
//  - Every request gives one result, except release with N queued waiters,
//    which gives N results (one per woken id); last marks the final one.
//  - A request's id compare is latched at the accept edge; the update step
//    then changes balance and queue and loads the output register once the
//    output register is free. A new request is taken only after the last
//    update step of the previous one; release with N waiters takes one
//    update step per woken id, since the cell row shifts by one slot per step.
//  - in_chan.ready is high whenever no request is in work, also while the
//    previous result still sits in the output register.
//  - A stalled out_chan holds the result; the update step waits until the
//    output register is free, so nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) clears the balance, the queue length and
//    the output valid; cell contents are don't-care until written.
//  - Full queue and balance overflow give a status code and change nothing.
module counting_semaphore_with_waiter_queue #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  csw_in_if.sink   in_chan,
  csw_out_if.source out_chan
);
  import csw_pkg::*;

  localparam int LenW = $clog2(MAX_WAITERS + 1);

  // control state
  state_t                   state_r, state_nxt;
  logic signed [31:0]       bal_r, bal_nxt;
  logic [LenW-1:0]          len_r, len_nxt;
  logic                     out_valid_r;

  // captured request
  logic [OPCODE_W-1:0]      op_r;
  logic [ID_WIDTH-1:0]      id_r;
  logic [ID_WIDTH+IN_ID_W-1:0] req_ext;

  // output payload registers
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_wv_r;
  logic [IN_ID_W-1:0]       out_wid_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic [WCOUNT_W-1:0]      out_wcount_r;
  logic                     out_last_r;

  // step results
  status_t                  st;
  logic                     wv;
  logic                     last;
  logic                     pop;
  logic                     rem;
  logic                     app;
  logic                     go;
  logic                     out_free;
  logic                     in_fire;
  logic                     found;
  logic [COUNT_W-1:0]       count_nxt;
  logic [LenW+WCOUNT_W-1:0] wc_ext;
  logic [ID_WIDTH+IN_ID_W-1:0] wid_ext;

  // cell row
  cell_ctrl_t               ctrl;
  logic [ID_WIDTH-1:0]      ids  [MAX_WAITERS];
  logic                     hits [MAX_WAITERS+1];

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;
  assign go       = (state_r == S_EXEC) && out_free;

  // only the low ID_WIDTH bits of the id take part
  assign req_ext  = {{ID_WIDTH{1'b0}}, in_chan.waiter_id};

  // compare uses the incoming id at accept; later steps use the stored one
  assign ctrl.capture = in_fire;
  assign ctrl.pop     = go && pop;
  assign ctrl.remove  = go && rem;
  assign ctrl.append  = go && app;

  assign hits[0] = 1'b0;
  assign found   = hits[MAX_WAITERS];

  for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
    logic [ID_WIDTH-1:0] nb_id;
    logic [ID_WIDTH-1:0] cmp_id;
    if (g == MAX_WAITERS - 1) begin : g_end
      assign nb_id = ids[g];
    end else begin : g_mid
      assign nb_id = ids[g+1];
    end
    assign cmp_id = in_fire ? req_ext[ID_WIDTH-1:0] : id_r;
    csw_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .req_id   (cmp_id),
      .occupied (LenW'(g) < len_r),
      .at_tail  (len_r == LenW'(g)),
      .next_id  (nb_id),
      .hit_in   (hits[g]),
      .hit_out  (hits[g+1]),
      .id_q     (ids[g])
    );
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_chan.opcode;
      id_r <= req_ext[ID_WIDTH-1:0];
    end
  end

  // update step: balance, queue control and result fields
  always_comb begin
    bal_nxt = bal_r;
    len_nxt = len_r;
    st      = ST_UNAVAILABLE;
    wv      = 1'b0;
    last    = 1'b1;
    pop     = 1'b0;
    rem     = 1'b0;
    app     = 1'b0;
    case (op_r)
      OP_SIGNAL: begin
        if (bal_r == BALANCE_TOP) begin
          st = ST_OVERFLOW;
        end else begin
          st      = ST_SIGNALLED;
          bal_nxt = bal_r + 32'sd1;
          if (bal_r < 0 && len_r != '0) begin
            pop     = 1'b1;
            wv      = 1'b1;
            len_nxt = len_r - LenW'(1);
          end
        end
      end
      OP_TRYWAIT: begin
        if (bal_r > 0) begin
          st      = ST_GRANTED;
          bal_nxt = bal_r - 32'sd1;
        end
      end
      OP_WAIT: begin
        if (bal_r > 0) begin
          st      = ST_GRANTED;
          bal_nxt = bal_r - 32'sd1;
        end else if (len_r >= LenW'(MAX_WAITERS)) begin
          st = ST_FULL;
        end else if (bal_r == BALANCE_BOTTOM) begin
          st = ST_OVERFLOW;
        end else begin
          st      = ST_QUEUED;
          bal_nxt = bal_r - 32'sd1;
          app     = 1'b1;
          len_nxt = len_r + LenW'(1);
        end
      end
      OP_TIMEOUT: begin
        if (found) begin
          st      = ST_TIMEDOUT;
          rem     = 1'b1;
          len_nxt = len_r - LenW'(1);
          if (bal_r != BALANCE_TOP) begin
            bal_nxt = bal_r + 32'sd1;
          end
        end else begin
          st = ST_ALREADY;
        end
      end
      OP_RELEASE: begin
        st      = ST_RELEASED;
        bal_nxt = '0;
        if (len_r != '0) begin
          pop     = 1'b1;
          wv      = 1'b1;
          len_nxt = len_r - LenW'(1);
          last    = (len_r == LenW'(1));
        end
      end
      default: begin
        st = ST_UNAVAILABLE;
      end
    endcase
  end

  assign count_nxt = (bal_nxt > 0) ? bal_nxt[COUNT_W-1:0] : '0;
  assign wc_ext    = {{WCOUNT_W{1'b0}}, len_nxt};
  assign wid_ext   = {{IN_ID_W{1'b0}}, ids[0]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go && last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bal_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        bal_r       <= bal_nxt;
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= st;
      out_wv_r     <= wv;
      out_wid_r    <= wv ? wid_ext[IN_ID_W-1:0] : '0;
      out_count_r  <= count_nxt;
      out_wcount_r <= wc_ext[WCOUNT_W-1:0];
      out_last_r   <= last;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.woken_valid   = out_wv_r;
  assign out_chan.woken_id      = out_wid_r;
  assign out_chan.event_count   = out_count_r;
  assign out_chan.waiting_count = out_wcount_r;
  assign out_chan.last          = out_last_r;

  // queue length never exceeds the cell count
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenW'(MAX_WAITERS))
    else $error("queue length beyond cell count");

  // each release step with queued waiters wakes exactly one waiter
  a_release_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && op_r == OP_RELEASE && len_r != '0) |=> (len_r == $past(len_r) - LenW'(1)))
    else $error("release did not pop one waiter");

  // a woken id only comes with signal or release
  a_woken_status: assert property (@(posedge clk) disable iff (!rst_n)
    (go && wv) |-> (st == ST_SIGNALLED || st == ST_RELEASED))
    else $error("woken waiter with wrong status");

  // a negative balance always has queued waiters behind it
  a_balance_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (bal_r < 0) |-> (len_r != '0))
    else $error("negative balance with empty queue");

endmodule

### rtl/csw_cell.sv
`timescale 1ns / 1ps
// One slot of the waiter queue: holds an id, compares it to a request and
// shifts from its neighbor behind it. Depends on csw_pkg.
module csw_cell #(
  parameter int ID_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csw_pkg::cell_ctrl_t  ctrl,
  input  logic [ID_WIDTH-1:0]  req_id,
  input  logic                 occupied,
  input  logic                 at_tail,
  input  logic [ID_WIDTH-1:0]  next_id,
  input  logic                 hit_in,
  output logic                 hit_out,
  output logic [ID_WIDTH-1:0]  id_q
);
  import csw_pkg::*;

  logic [ID_WIDTH-1:0] id_r;
  logic [ID_WIDTH-1:0] id_nxt;
  logic                match_r;
  logic                shift;

  // first match ripples down the row: every cell from it on closes the gap
  assign hit_out = hit_in | match_r;
  assign shift   = ctrl.pop | (ctrl.remove & hit_out);
  assign id_q    = id_r;

  always_comb begin
    if (shift) begin
      id_nxt = next_id;
    end else if (ctrl.append && at_tail) begin
      id_nxt = req_id;
    end else begin
      id_nxt = id_r;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.capture) begin
      match_r <= occupied && (id_r == req_id);
    end
  end

endmodule
